// ----- hdl/lrup_pkg.sv -----
// Shared types and constants of the LRU pool with idle expiry.
package lrup_pkg;

  localparam int MAX_IDX_W  = 8;
  localparam int MAX_CNT_W  = 9;
  localparam int MAX_KEY_W  = 64;
  localparam int MAX_TIME_W = 64;
  localparam int LIMIT_W    = 32;

  localparam logic [LIMIT_W-1:0] EXPIRY_RESET = 32'd1800;

  typedef enum logic [2:0] {
    STATUS_HIT     = 3'd0,
    STATUS_FILLED  = 3'd1,
    STATUS_EVICTED = 3'd2,
    STATUS_NO_OPEN = 3'd3,
    STATUS_SWEPT   = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Item broadcast to every cell while it walks down the chain.
  typedef struct packed {
    logic                  action;
    logic                  open_ok;
    logic [MAX_KEY_W-1:0]  key;
    logic [MAX_TIME_W-1:0] now;
    logic [LIMIT_W-1:0]    limit;
  } query_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic                  valid;
    logic                  matched;
    logic                  hit;
    logic [MAX_IDX_W-1:0]  hit_idx;
    logic                  free_found;
    logic [MAX_IDX_W-1:0]  free_idx;
    logic                  best_seen;
    logic [MAX_TIME_W-1:0] best_age;
    logic [MAX_IDX_W-1:0]  best_idx;
    logic [MAX_KEY_W-1:0]  best_key;
    logic [MAX_CNT_W-1:0]  dropped;
  } token_t;

  typedef struct packed {
    logic                 en;
    logic [MAX_IDX_W-1:0] idx;
  } fill_t;

endpackage

// ----- hdl/lrup_cell.sv -----
// One pool slot: holds an entry and updates the scan token passing through it.
module lrup_cell #(
  parameter int MY_IDX    = 0,
  parameter int KEY_BITS  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lrup_pkg::query_t query,
  input  lrup_pkg::fill_t  fill,
  input  lrup_pkg::token_t tok_i,
  output lrup_pkg::token_t tok_o
);

  logic                 valid_r, valid_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  lrup_pkg::token_t     tok_r, tok_nxt;

  logic [TIME_BITS-1:0]            now_c;
  logic [TIME_BITS-1:0]            age;
  logic [lrup_pkg::MAX_TIME_W-1:0] age_w;
  logic                            stale;
  logic                            match;
  logic [lrup_pkg::MAX_IDX_W-1:0]  my_idx;

  assign my_idx = lrup_pkg::MAX_IDX_W'(MY_IDX);
  assign now_c  = query.now[TIME_BITS-1:0];
  assign age    = now_c - last_r;
  assign age_w  = lrup_pkg::MAX_TIME_W'(age);
  assign stale  = age_w > lrup_pkg::MAX_TIME_W'(query.limit);
  assign match  = valid_r && (key_r == query.key[KEY_BITS-1:0]);

  always_comb begin
    tok_nxt   = tok_i;
    valid_nxt = valid_r;
    key_nxt   = key_r;
    last_nxt  = last_r;
    if (tok_i.valid) begin
      if (query.action) begin
        if (valid_r && stale) begin
          valid_nxt       = 1'b0;
          tok_nxt.dropped = tok_i.dropped + lrup_pkg::MAX_CNT_W'(1);
        end
      end else begin
        if (!tok_i.matched && match) begin
          tok_nxt.matched = 1'b1;
          if (stale) begin
            valid_nxt       = 1'b0;
            tok_nxt.dropped = lrup_pkg::MAX_CNT_W'(1);
          end else begin
            tok_nxt.hit     = 1'b1;
            tok_nxt.hit_idx = my_idx;
            last_nxt        = now_c;
          end
        end
        if (!tok_i.free_found && !valid_nxt) begin
          tok_nxt.free_found = 1'b1;
          tok_nxt.free_idx   = my_idx;
        end else if (valid_nxt && (!tok_i.best_seen || age_w > tok_i.best_age)) begin
          tok_nxt.best_seen = 1'b1;
          tok_nxt.best_age  = age_w;
          tok_nxt.best_idx  = my_idx;
          tok_nxt.best_key  = lrup_pkg::MAX_KEY_W'(key_r);
        end
      end
    end
    if (fill.en && fill.idx == my_idx) begin
      valid_nxt = 1'b1;
      key_nxt   = query.key[KEY_BITS-1:0];
      last_nxt  = now_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    last_r <= last_nxt;
  end

  assign tok_o = tok_r;

endmodule

// ----- hdl/lru_pool_with_idle_expiry.sv -----
// Top level of the LRU pool with idle expiry: query registers, cell chain and result stage.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   input   | start, busy          | in_action, in_key_tag, in_now_time, in_open_ok
//   result  | out_valid (strobe)   | out_status, out_slot_index, out_evicted_key,
//           |                      | out_dropped_count
//   config  | cfg_wr_en            | cfg_wr_data (expiry limit)
//
// An item walks the chain one cell per cycle, and a new item is taken only while busy is low.
// The result strobe comes once the item has left the last cell, and busy drops in that same
// cycle, so only one item is in the chain at a time.
// After reset the pool is empty and the expiry limit is 1800; no clearing pass is needed.
// Each result is shown for one cycle and the receiver cannot stall it.
module lru_pool_with_idle_expiry #(
  parameter int POOL_ENTRIES = 64,
  parameter int KEY_BITS     = 64,
  parameter int TIME_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [63:0] in_key_tag,
  input  logic [31:0] in_now_time,
  input  logic        in_open_ok,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_index,
  output logic [63:0] out_evicted_key,
  output logic [6:0]  out_dropped_count,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  lrup_pkg::state_t  state_r, state_nxt;
  lrup_pkg::query_t  query_r;
  lrup_pkg::fill_t   fill;
  lrup_pkg::token_t  tok [POOL_ENTRIES+1];
  lrup_pkg::token_t  last_tok;
  lrup_pkg::status_t status_nxt;

  logic [31:0]             expiry_r;
  logic                    go_r;
  logic                    accept;
  logic                    done;
  logic [POOL_ENTRIES-1:0] tok_live;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [5:0]  out_slot_r, slot_nxt;
  logic [63:0] out_evicted_r, evicted_nxt;
  logic [6:0]  out_dropped_r;

  assign accept   = start && (state_r == lrup_pkg::S_IDLE);
  assign busy     = (state_r != lrup_pkg::S_IDLE);
  assign last_tok = tok[POOL_ENTRIES];
  assign done     = last_tok.valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrup_pkg::S_IDLE: if (accept) state_nxt = lrup_pkg::S_SCAN;
      lrup_pkg::S_SCAN: if (done) state_nxt = lrup_pkg::S_IDLE;
      default:          state_nxt = lrup_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    fill        = '0;
    status_nxt  = lrup_pkg::STATUS_HIT;
    slot_nxt    = '0;
    evicted_nxt = '0;
    if (query_r.action) begin
      status_nxt = lrup_pkg::STATUS_SWEPT;
    end else if (last_tok.hit) begin
      status_nxt = lrup_pkg::STATUS_HIT;
      slot_nxt   = 6'(last_tok.hit_idx);
    end else if (!query_r.open_ok) begin
      status_nxt = lrup_pkg::STATUS_NO_OPEN;
    end else if (last_tok.free_found) begin
      status_nxt = lrup_pkg::STATUS_FILLED;
      slot_nxt   = 6'(last_tok.free_idx);
      fill.en    = done;
      fill.idx   = last_tok.free_idx;
    end else begin
      status_nxt  = lrup_pkg::STATUS_EVICTED;
      slot_nxt    = 6'(last_tok.best_idx);
      evicted_nxt = 64'(last_tok.best_key);
      fill.en     = done;
      fill.idx    = last_tok.best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrup_pkg::S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      expiry_r    <= lrup_pkg::EXPIRY_RESET;
    end else begin
      state_r     <= state_nxt;
      go_r        <= accept;
      out_valid_r <= done;
      if (cfg_wr_en) begin
        expiry_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query_r.action  <= in_action;
      query_r.open_ok <= in_open_ok;
      query_r.key     <= lrup_pkg::MAX_KEY_W'(in_key_tag[KEY_BITS-1:0]);
      query_r.now     <= lrup_pkg::MAX_TIME_W'(TIME_BITS'(in_now_time));
      query_r.limit   <= expiry_r;
    end
    if (done) begin
      out_status_r  <= status_nxt;
      out_slot_r    <= slot_nxt;
      out_evicted_r <= evicted_nxt;
      out_dropped_r <= 7'(last_tok.dropped);
    end
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = go_r;
  end

  for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
    lrup_cell #(
      .MY_IDX    (i),
      .KEY_BITS  (KEY_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .query (query_r),
      .fill  (fill),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
    assign tok_live[i] = tok[i+1].valid;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_index    = out_slot_r;
  assign out_evicted_key   = out_evicted_r;
  assign out_dropped_count = out_dropped_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_live, go_r}))
    else $error("more than one item in the cell chain");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == lrup_pkg::S_SCAN)
    else $error("scan token arrived while idle");

  a_fill_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    fill.en |-> !last_tok.hit && !query_r.action && query_r.open_ok)
    else $error("slot filled on a hit, sweep or failed open");

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid && !busy)
    else $error("result strobe missing after scan");

endmodule

// ----- tb/lru_pool_scoreboard_pkg.sv -----
// Scoreboard for the LRU pool: its own model of the pool and a queue of awaited results.
package lru_pool_scoreboard_pkg;

  typedef struct packed {
    lrup_pkg::status_t status;
    logic [5:0]        slot;
    logic [63:0]       evicted;
    logic [6:0]        dropped;
  } pool_outcome_t;

  class lru_pool_scoreboard;

    bit            entry_live [64];
    bit [63:0]     entry_tag  [64];
    bit [31:0]     entry_stamp[64];
    bit [31:0]     idle_limit;
    pool_outcome_t outcome_q[$];
    int            error_count;

    function new();
      foreach (entry_live[i]) begin
        entry_live[i]  = 1'b0;
        entry_tag[i]   = '0;
        entry_stamp[i] = '0;
      end
      idle_limit  = lrup_pkg::EXPIRY_RESET;
      error_count = 0;
    endfunction

    function void set_limit(bit [31:0] value);
      idle_limit = value;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function void note_request(bit action, bit [63:0] key, bit [31:0] now, bit open_ok);
      pool_outcome_t o;
      bit [31:0]     age;
      bit [31:0]     best_age;
      bit            matched;
      bit            hit;
      bit            found_free;
      int            slot;
      o.status  = lrup_pkg::STATUS_SWEPT;
      o.slot    = '0;
      o.evicted = '0;
      o.dropped = '0;
      if (action) begin
        for (int i = 0; i < 64; i++) begin
          age = now - entry_stamp[i];
          if (entry_live[i] && age > idle_limit) begin
            entry_live[i] = 1'b0;
            o.dropped     = o.dropped + 7'd1;
          end
        end
      end else begin
        matched = 1'b0;
        hit     = 1'b0;
        for (int i = 0; i < 64; i++) begin
          if (!matched && entry_live[i] && entry_tag[i] == key) begin
            matched = 1'b1;
            age     = now - entry_stamp[i];
            if (age > idle_limit) begin
              entry_live[i] = 1'b0;
              o.dropped     = 7'd1;
            end else begin
              entry_stamp[i] = now;
              hit            = 1'b1;
              o.status       = lrup_pkg::STATUS_HIT;
              o.slot         = i[5:0];
            end
          end
        end
        if (!hit) begin
          if (!open_ok) begin
            o.status = lrup_pkg::STATUS_NO_OPEN;
          end else begin
            found_free = 1'b0;
            slot       = 0;
            best_age   = '0;
            for (int i = 0; i < 64; i++) begin
              if (!found_free) begin
                if (!entry_live[i]) begin
                  slot       = i;
                  found_free = 1'b1;
                end else begin
                  age = now - entry_stamp[i];
                  if (i == 0 || age > best_age) begin
                    best_age = age;
                    slot     = i;
                  end
                end
              end
            end
            o.status  = found_free ? lrup_pkg::STATUS_FILLED : lrup_pkg::STATUS_EVICTED;
            o.evicted = found_free ? 64'd0 : entry_tag[slot];
            o.slot    = slot[5:0];
            entry_live[slot]  = 1'b1;
            entry_tag[slot]   = key;
            entry_stamp[slot] = now;
          end
        end
      end
      outcome_q.push_back(o);
    endfunction

    function void check_outcome(logic [2:0] status, logic [5:0] slot, logic [63:0] evicted,
                                logic [6:0] dropped);
      pool_outcome_t o;
      if (outcome_q.size() == 0) begin
        $error("result with no item outstanding: status %0d slot %0d", status, slot);
        error_count++;
        return;
      end
      o = outcome_q.pop_front();
      if (status !== o.status) begin
        $error("status: expected %0d, actual %0d", o.status, status);
        error_count++;
      end
      if (slot !== o.slot) begin
        $error("slot_index: expected %0d, actual %0d", o.slot, slot);
        error_count++;
      end
      if (evicted !== o.evicted) begin
        $error("evicted_key: expected %0h, actual %0h", o.evicted, evicted);
        error_count++;
      end
      if (dropped !== o.dropped) begin
        $error("dropped_count: expected %0d, actual %0d", o.dropped, dropped);
        error_count++;
      end
    endfunction

  endclass

endpackage

// ----- tb/tb_lru_pool_with_idle_expiry.sv -----
// Testbench top for the LRU pool with idle expiry: directed and random items against a scoreboard.
module tb_lru_pool_with_idle_expiry;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 80;
  localparam int KEY_POOL     = 80;
  localparam int DRAIN_CYCLES = 80;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        start             = 1'b0;
  logic        busy;
  logic        in_action         = 1'b0;
  logic [63:0] in_key_tag        = '0;
  logic [31:0] in_now_time       = '0;
  logic        in_open_ok        = 1'b0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [5:0]  out_slot_index;
  logic [63:0] out_evicted_key;
  logic [6:0]  out_dropped_count;
  logic        cfg_wr_en         = 1'b0;
  logic [31:0] cfg_wr_data       = '0;

  lru_pool_scoreboard_pkg::lru_pool_scoreboard sb;
  int          cycle_count = 0;
  bit          idle_on     = 1'b1;
  bit [31:0]   cur_time;
  bit [63:0]   last_key;
  bit [63:0]   key_pool[KEY_POOL];
  bit [31:0]   phase_limit[6];

  lru_pool_with_idle_expiry DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_key_tag       (in_key_tag),
    .in_now_time      (in_now_time),
    .in_open_ok       (in_open_ok),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_evicted_key  (out_evicted_key),
    .out_dropped_count(out_dropped_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL lru_pool_with_idle_expiry");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_outcome(out_status, out_slot_index, out_evicted_key, out_dropped_count);
    end
  end

  task automatic send_item(bit action, bit [63:0] key, bit [31:0] now, bit open_ok);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_action   <= action;
    in_key_tag  <= key;
    in_now_time <= now;
    in_open_ok  <= open_ok;
    do begin
      @(posedge clk);
    end while (busy);
    sb.note_request(action, key, now, open_ok);
  endtask

  task automatic write_limit(bit [31:0] value);
    start <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(value);
  endtask

  task automatic random_item(bit [31:0] limit);
    bit [31:0] span;
    bit [63:0] key;
    bit [31:0] now;
    int        pick;
    span = limit / 32 + 2;
    cur_time = cur_time + $urandom_range(0, span);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      cur_time = $urandom;
      now = cur_time;
    end else if (pick < 5) begin
      now = cur_time - $urandom_range(1, 1000);
    end else begin
      now = cur_time;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      key = last_key;
    end else if (pick < 80) begin
      key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end else begin
      key = {$urandom, $urandom};
    end
    last_key = key;
    send_item($urandom_range(0, 99) < 8, key, now, $urandom_range(0, 99) < 85);
  endtask

  initial begin
    sb = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end
    phase_limit = '{32'd64, 32'd1, 32'hFFFF_FFFF, 32'd0, $urandom_range(200, 200000),
                    lrup_pkg::EXPIRY_RESET};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(1'b0, 64'd0, 32'd100, 1'b0);
    send_item(1'b1, '1, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b0, 64'd0, 32'd100, 1'b1);
    send_item(1'b0, '1, 32'd200, 1'b1);
    send_item(1'b0, 64'd0, 32'd1900, 1'b1);
    send_item(1'b0, '1, 32'd2001, 1'b0);
    send_item(1'b0, '1, 32'd2001, 1'b1);
    send_item(1'b0, 64'd0, 32'd5000, 1'b1);
    send_item(1'b0, 64'h5555_5555_5555_5555, 32'hFFFF_FF00, 1'b1);
    send_item(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFF0, 1'b1);
    send_item(1'b0, 64'h5555_5555_5555_5555, 32'h0000_0100, 1'b1);
    send_item(1'b0, 64'h1234_5678_9ABC_DEF0, 32'h0000_0050, 1'b1);
    send_item(1'b0, 64'h1234_5678_9ABC_DEF0, 32'h0000_0040, 1'b1);
    send_item(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0000_0040, 1'b0);
    send_item(1'b1, 64'h5555_5555_5555_5555, 32'h0000_0900, 1'b1);
    send_item(1'b0, 64'h5555_5555_5555_5555, 32'h0000_0900, 1'b0);
    send_item(1'b1, 64'd0, 32'h8000_0000, 1'b0);

    cur_time = $urandom;
    last_key = key_pool[0];
    for (int p = 0; p < 6; p++) begin
      write_limit(phase_limit[p]);
      idle_on = (p != 5);
      repeat (PHASE_ITEMS) random_item(phase_limit[p]);
    end

    start <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("PASS lru_pool_with_idle_expiry");
    end else begin
      $display("FAIL lru_pool_with_idle_expiry");
    end
    $finish;
  end

endmodule
